>>> rtl/servo_command_frame_parser_defines.svh
// Assertion macros shared by the frame parser RTL
`ifndef SERVO_COMMAND_FRAME_PARSER_DEFINES_SVH
`define SERVO_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SCFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scfp assertion failed");

// Next-cycle implication, checked on every rising edge outside reset
`define SCFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scfp assertion failed");

`endif

>>> rtl/scfp_pkg.sv
// Package: types, register map and character codes of the frame parser
package scfp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ANGLE_W = 10;
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;

	// Register indexes (word address paddr[3:2])
	localparam logic [1:0] REG_START_BYTE = 2'd0;
	localparam logic [1:0] REG_END_BYTE   = 2'd1;
	localparam logic [1:0] REG_MAX_ANGLE  = 2'd2;

	// Reset values of the registers
	localparam logic [BYTE_W-1:0]  START_BYTE_RST = 8'h02;
	localparam logic [BYTE_W-1:0]  END_BYTE_RST   = 8'h03;
	localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST  = 10'd180;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// Configuration seen by the parser
	typedef struct packed {
		logic [BYTE_W-1:0]  start_byte;
		logic [BYTE_W-1:0]  end_byte;
		logic [ANGLE_W-1:0] max_angle;
	} cfg_t;

	// Offset of the next byte within a frame
	typedef enum logic [2:0] {
		POS_HUNT = 3'd0,
		POS_CMD  = 3'd1,
		POS_V0   = 3'd2,
		POS_V1   = 3'd3,
		POS_V2   = 3'd4,
		POS_END  = 3'd5
	} pos_t;

	// Progress through the value characters
	typedef enum logic [1:0] {
		PH_PRE    = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

>>> rtl/scfp_if.sv
// Stream channels: received bytes in, decoded angles out
interface scfp_rx_if;
	import scfp_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfp_angle_if;
	import scfp_pkg::*;
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink   (input valid, input angle, output ready);
endinterface

>>> rtl/scfp_apb_regs.sv
// APB register block: start byte, end byte and angle limit
module scfp_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scfp_pkg::ADDR_W-1:0] paddr,
	input  logic [scfp_pkg::DATA_W-1:0] pwdata,
	output logic [scfp_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output scfp_pkg::cfg_t              cfg
);
	import scfp_pkg::*;

	logic [1:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.end_byte   <= END_BYTE_RST;
			cfg_q.max_angle  <= MAX_ANGLE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_BYTE: cfg_q.start_byte <= pwdata[BYTE_W-1:0];
				REG_END_BYTE:   cfg_q.end_byte   <= pwdata[BYTE_W-1:0];
				REG_MAX_ANGLE:  cfg_q.max_angle  <= pwdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_START_BYTE: prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.start_byte};
			REG_END_BYTE:   prdata = {{(DATA_W-BYTE_W){1'b0}}, cfg_q.end_byte};
			REG_MAX_ANGLE:  prdata = {{(DATA_W-ANGLE_W){1'b0}}, cfg_q.max_angle};
			default:        prdata = '0;
		endcase
	end

endmodule

>>> rtl/servo_command_frame_parser.sv
// Top level: servo command frame parser
// Takes one received byte per beat on rx_ch and hunts for the start byte; a frame is start,
// command byte, three value characters and the end byte at offset five. Leading white space
// and a plus sign are skipped, decimal digits are read up to the first non-digit, and a frame
// with at least one digit and a value no larger than max_angle gives one angle beat on
// angle_ch. Throughput is one byte per cycle unless a held angle waits on angle_ch: the byte
// goes into an input register, the frame state and result are worked out combinationally and
// land in the output register, which may hold a result while the next byte is taken.
// Registers (APB, word addresses): 0x0 start byte (reset 0x02), 0x4 end byte (reset 0x03),
// 0x8 max angle (reset 180); write them only while the parser is idle.
`include "servo_command_frame_parser_defines.svh"

module servo_command_frame_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scfp_pkg::ADDR_W-1:0] paddr,
	input  logic [scfp_pkg::DATA_W-1:0] pwdata,
	output logic [scfp_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	scfp_rx_if.sink                     rx_ch,
	scfp_angle_if.source                angle_ch
);
	import scfp_pkg::*;

	cfg_t               cfg;

	// Input register
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;

	// Frame state
	pos_t               pos_q, pos_d;
	phase_t             phase_q, phase_d;
	logic [ANGLE_W-1:0] acc_q, acc_d;
	logic               bad_q, bad_d;

	// Output register
	logic               out_valid_q;
	logic [ANGLE_W-1:0] angle_q;

	logic               advance;
	logic               res_valid;
	logic               is_end;
	logic [ANGLE_W-1:0] digit_val;
	logic [ANGLE_W-1:0] acc_x10;

	scfp_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1 moves on whenever the output register is free or being drained
	assign advance        = !out_valid_q || angle_ch.ready;
	assign rx_ch.ready    = !valid_s1 || advance;
	assign angle_ch.valid = out_valid_q;
	assign angle_ch.angle = angle_q;

	assign is_end    = (byte_s1 == cfg.end_byte);
	assign digit_val = {{(ANGLE_W-4){1'b0}}, byte_s1[3:0]};
	assign acc_x10   = (acc_q << 3) + (acc_q << 1);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ch.ready) begin
			valid_s1 <= rx_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ch.ready) begin
			byte_s1 <= rx_ch.rx_byte;
		end
	end

	// Next frame state
	always_comb begin
		pos_d   = pos_q;
		phase_d = phase_q;
		acc_d   = acc_q;
		bad_d   = bad_q;
		unique case (pos_q)
			POS_HUNT: begin
				pos_d = (byte_s1 == cfg.start_byte) ? POS_CMD : POS_HUNT;
			end
			POS_CMD: begin
				if (is_end) begin
					pos_d = (byte_s1 == cfg.start_byte) ? POS_CMD : POS_HUNT;
				end else begin
					pos_d = POS_V0;
				end
			end
			POS_V0, POS_V1, POS_V2: begin
				if (is_end) begin
					pos_d   = (byte_s1 == cfg.start_byte) ? POS_CMD : POS_HUNT;
					phase_d = PH_PRE;
					acc_d   = '0;
					bad_d   = 1'b0;
				end else begin
					pos_d = (pos_q == POS_V2) ? POS_END :
						(pos_q == POS_V1) ? POS_V2 : POS_V1;
					unique case (phase_q)
						PH_PRE: begin
							if (is_blank(byte_s1)) begin
								phase_d = PH_PRE;
							end else if (byte_s1 == CH_PLUS) begin
								phase_d = PH_SIGN;
							end else if (is_digit(byte_s1)) begin
								acc_d   = digit_val;
								phase_d = PH_DIGITS;
							end else begin
								bad_d   = 1'b1;
								phase_d = PH_DONE;
							end
						end
						PH_SIGN: begin
							if (is_digit(byte_s1)) begin
								acc_d   = digit_val;
								phase_d = PH_DIGITS;
							end else begin
								bad_d   = 1'b1;
								phase_d = PH_DONE;
							end
						end
						PH_DIGITS: begin
							if (is_digit(byte_s1)) begin
								acc_d = acc_x10 + digit_val;
							end else begin
								phase_d = PH_DONE;
							end
						end
						default: ;
					endcase
				end
			end
			POS_END: begin
				// a good end byte closes the frame; anything else may open a new one
				phase_d = PH_PRE;
				acc_d   = '0;
				bad_d   = 1'b0;
				pos_d   = (!is_end && byte_s1 == cfg.start_byte) ? POS_CMD : POS_HUNT;
			end
			default: begin
				phase_d = PH_PRE;
				acc_d   = '0;
				bad_d   = 1'b0;
				pos_d   = (byte_s1 == cfg.start_byte) ? POS_CMD : POS_HUNT;
			end
		endcase
	end

	// Result of the current byte
	always_comb begin
		res_valid = 1'b0;
		unique case (pos_q)
			POS_END: begin
				res_valid = is_end && !bad_q &&
					(phase_q == PH_DIGITS || phase_q == PH_DONE) &&
					(acc_q <= cfg.max_angle);
			end
			default: res_valid = 1'b0;
		endcase
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_HUNT;
			phase_q <= PH_PRE;
			acc_q   <= '0;
			bad_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			pos_q   <= pos_d;
			phase_q <= phase_d;
			acc_q   <= acc_d;
			bad_q   <= bad_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			angle_q <= acc_q;
		end
	end

	// Checks
	`SCFP_ASSERT_NOW(a_res_at_end, valid_s1 && res_valid, pos_q == POS_END && !bad_q)
	`SCFP_ASSERT_NOW(a_angle_in_limit, out_valid_q, angle_q <= cfg.max_angle)
	`SCFP_ASSERT_NEXT(a_end_closes, valid_s1 && advance && pos_q == POS_END && is_end,
		pos_q == POS_HUNT && phase_q == PH_PRE && !bad_q)

endmodule
